>>> rtl/core/aabb_pcf_pkg.sv
// Shared types and constants for the AABB pair collision finder.
// Holds the controller/datapath command and status groups and the id width.
// No dependencies.
package aabb_pcf_pkg;

  localparam int unsigned IdW = 16;

  // Entity flags as kept in the table
  localparam int unsigned FlagStatic = 0;
  localparam int unsigned FlagBox    = 1;

  // Request decode fields seen by the controller
  typedef struct packed {
    logic mode;
    logic active;
    logic is_static;
    logic is_box;
  } req_kind_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;   // capture the incoming entity
    logic clear;   // empty the table
    logic rd_en;   // read the next table entry
    logic step;    // advance the scan pipeline
    logic push;    // take the current hit into the pending slot
    logic flush;   // move the pending hit out as the last one
    logic store;   // write the captured entity into the table
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;       // current read entry overlaps the captured box
    logic pend_v;    // pending slot holds a hit
    logic out_free;  // output register can load this cycle
    logic rd_more;   // table entries left to read
  } sts_t;

endpackage

>>> rtl/core/aabb_pcf_in_if.sv
// Request channel of the AABB pair collision finder: one entity per request.
// Depends on nothing; width of the box corners set by COORD_WIDTH.
interface aabb_pcf_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [15:0]                   entity_id;
  logic                          active;
  logic                          is_static;
  logic                          is_box;
  logic signed [COORD_WIDTH-1:0] min_x;
  logic signed [COORD_WIDTH-1:0] min_y;
  logic signed [COORD_WIDTH-1:0] max_x;
  logic signed [COORD_WIDTH-1:0] max_y;

  modport source (
    output valid, mode, entity_id, active, is_static, is_box, min_x, min_y, max_x, max_y,
    input  ready
  );
  modport sink (
    input  valid, mode, entity_id, active, is_static, is_box, min_x, min_y, max_x, max_y,
    output ready
  );
endinterface

>>> rtl/core/aabb_pcf_res_if.sv
// Result channel of the AABB pair collision finder: one collision record per overlapping pair.
// Depends on nothing; width of the contact corners set by COORD_WIDTH.
interface aabb_pcf_res_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [15:0]                   entity_a;
  logic [15:0]                   entity_b;
  logic                          b_static;
  logic                          normal_on_x;
  logic                          normal_a_positive;
  logic signed [COORD_WIDTH-1:0] contact_a_x;
  logic signed [COORD_WIDTH-1:0] contact_a_y;
  logic signed [COORD_WIDTH-1:0] contact_b_x;
  logic signed [COORD_WIDTH-1:0] contact_b_y;
  logic                          last;

  modport source (
    output valid, entity_a, entity_b, b_static, normal_on_x, normal_a_positive,
           contact_a_x, contact_a_y, contact_b_x, contact_b_y, last,
    input  ready
  );
  modport sink (
    input  valid, entity_a, entity_b, b_static, normal_on_x, normal_a_positive,
           contact_a_x, contact_a_y, contact_b_x, contact_b_y, last,
    output ready
  );
endinterface

>>> rtl/core/aabb_pcf_ctrl.sv
// Controller of the AABB pair collision finder: request decode and scan sequencing.
// Depends on aabb_pcf_pkg for the command and status groups.
module aabb_pcf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  aabb_pcf_pkg::req_kind_t kind_i,
  input  aabb_pcf_pkg::sts_t     sts_i,
  output aabb_pcf_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush,
    StStore
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        ready_o = 1'b1;
        if (valid_i) begin
          cmd_o.latch = 1'b1;
          if (kind_i.mode) begin
            cmd_o.clear = 1'b1;
          end else if (kind_i.active) begin
            if (kind_i.is_static || !kind_i.is_box) begin
              state_d = StStore;
            end else begin
              state_d = StScan;
            end
          end
        end
      end
      StScan: begin
        // hold the scan while a new hit has nowhere to go
        cmd_o.step = !(sts_i.hit && sts_i.pend_v && !sts_i.out_free);
        if (cmd_o.step) begin
          cmd_o.rd_en = sts_i.rd_more;
          cmd_o.push  = sts_i.hit;
          if (!sts_i.rd_more) begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        if (!sts_i.pend_v) begin
          state_d = StStore;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StStore;
        end
      end
      StStore: begin
        cmd_o.store = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/aabb_pcf_dp.sv
// Datapath of the AABB pair collision finder: entity table, overlap test,
// pending hit slot and output register. Depends on aabb_pcf_pkg and both channel interfaces.
module aabb_pcf_dp #(
  parameter int unsigned MAX_ENTITIES = 64,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  aabb_pcf_in_if.sink         req_i,
  aabb_pcf_res_if.source      res_o,
  input  aabb_pcf_pkg::cmd_t  cmd_i,
  output aabb_pcf_pkg::sts_t  sts_o
);

  localparam int unsigned AW   = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTITIES + 1);
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned IdW  = aabb_pcf_pkg::IdW;

  typedef struct packed {
    logic [1:0]    flags;
    logic [IdW-1:0] id;
    logic [CW-1:0] hiy;
    logic [CW-1:0] hix;
    logic [CW-1:0] loy;
    logic [CW-1:0] lox;
  } entry_t;

  typedef struct packed {
    logic [IdW-1:0] a_id;
    logic [IdW-1:0] b_id;
    logic          b_static;
    logic          on_x;
    logic          pos;
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
  } hit_t;

  entry_t          mem_q [MAX_ENTITIES];
  entry_t          a_q;
  entry_t          rd_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] raddr_q;
  logic            rv_q;
  logic            full;

  hit_t            pend_q;
  logic            pend_v_q;
  hit_t            out_q;
  logic            out_last_q;
  logic            out_v_q;
  hit_t            hit_new;
  logic            out_free;

  logic            ovl;
  logic            hx_lt;
  logic            hy_lt;
  logic [CW-1:0]   min_hx;
  logic [CW-1:0]   max_lx;
  logic [CW-1:0]   min_hy;
  logic [CW-1:0]   max_ly;
  logic signed [CW:0] ox;
  logic signed [CW:0] oy;
  logic            on_x;

  assign full = (cnt_q == CntW'(MAX_ENTITIES));

  // capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      a_q.lox   <= req_i.min_x;
      a_q.loy   <= req_i.min_y;
      a_q.hix   <= req_i.max_x;
      a_q.hiy   <= req_i.max_y;
      a_q.id    <= req_i.entity_id;
      a_q.flags[aabb_pcf_pkg::FlagStatic] <= req_i.is_static;
      a_q.flags[aabb_pcf_pkg::FlagBox]    <= req_i.is_box;
    end
  end

  // entity table
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem_q[cnt_q[AW-1:0]] <= a_q;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[raddr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      raddr_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.store && !full) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.latch) begin
        raddr_q <= '0;
        rv_q    <= 1'b0;
      end else if (cmd_i.step) begin
        rv_q <= cmd_i.rd_en;
        if (cmd_i.rd_en) begin
          raddr_q <= raddr_q + CntW'(1);
        end
      end
    end
  end

  // overlap test of the captured box against the entry just read
  always_comb begin
    ovl = !(($signed(a_q.hix) < $signed(rd_q.lox)) || ($signed(a_q.lox) > $signed(rd_q.hix)) ||
            ($signed(a_q.hiy) < $signed(rd_q.loy)) || ($signed(a_q.loy) > $signed(rd_q.hiy)));
    hx_lt  = $signed(a_q.hix) < $signed(rd_q.hix);
    hy_lt  = $signed(a_q.hiy) < $signed(rd_q.hiy);
    min_hx = hx_lt ? a_q.hix : rd_q.hix;
    min_hy = hy_lt ? a_q.hiy : rd_q.hiy;
    max_lx = ($signed(a_q.lox) > $signed(rd_q.lox)) ? a_q.lox : rd_q.lox;
    max_ly = ($signed(a_q.loy) > $signed(rd_q.loy)) ? a_q.loy : rd_q.loy;
    ox     = $signed({min_hx[CW-1], min_hx}) - $signed({max_lx[CW-1], max_lx});
    oy     = $signed({min_hy[CW-1], min_hy}) - $signed({max_ly[CW-1], max_ly});
    on_x   = ox < oy;

    hit_new.a_id     = a_q.id;
    hit_new.b_id     = rd_q.id;
    hit_new.b_static = rd_q.flags[aabb_pcf_pkg::FlagStatic];
    hit_new.on_x     = on_x;
    hit_new.pos      = on_x ? !hx_lt : !hy_lt;
    hit_new.ax       = a_q.lox;
    hit_new.ay       = a_q.loy;
    hit_new.bx       = rd_q.lox;
    hit_new.by       = rd_q.loy;
  end

  assign out_free = !out_v_q || res_o.ready;

  // pending slot: a hit is known to be the last only when the scan ends
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pend_q <= hit_new;
    end
    if (cmd_i.push && pend_v_q) begin
      out_q      <= pend_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.flush) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if ((cmd_i.push && pend_v_q) || cmd_i.flush) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign sts_o.hit      = rv_q && rd_q.flags[aabb_pcf_pkg::FlagBox] && ovl;
  assign sts_o.pend_v   = pend_v_q;
  assign sts_o.out_free = out_free;
  assign sts_o.rd_more  = raddr_q < cnt_q;

  assign res_o.valid             = out_v_q;
  assign res_o.entity_a          = out_q.a_id;
  assign res_o.entity_b          = out_q.b_id;
  assign res_o.b_static          = out_q.b_static;
  assign res_o.normal_on_x       = out_q.on_x;
  assign res_o.normal_a_positive = out_q.pos;
  assign res_o.contact_a_x       = out_q.ax;
  assign res_o.contact_a_y       = out_q.ay;
  assign res_o.contact_b_x       = out_q.bx;
  assign res_o.contact_b_y       = out_q.by;
  assign res_o.last              = out_last_q;

endmodule

>>> rtl/core/aabb_pair_collision_finder_unit.sv
// AABB pair collision finder: finds overlapping 2D boxes among the entities of a frame.
// req_i takes one entity per request (or a clear request that empties the table);
// res_o gives one collision record per overlapping pair, last set on the final one.
// A dynamic box entity is compared against every stored entity, oldest first, at one
// table read per cycle from the single read port of the entity table while the scan
// is not stalled; any pending record is then flushed and the entity is stored.
// Static and non-box entities are stored without a scan; clear and inactive requests
// are taken without leaving idle. req_i is ready only between requests.
// Each record is held back one hit so that last can be set: it moves from the pending slot
// to the output register and reaches res_o once the next hit or the end of the scan
// releases it. A stalled receiver stops the scan only while both the output register
// and the pending record are full.
// Reset empties the table and drops any pending record; the table contents are not
// cleared, only the entry count. Entities beyond MAX_ENTITIES are tested but not stored.
// Depends on aabb_pcf_pkg, aabb_pcf_in_if, aabb_pcf_res_if, aabb_pcf_ctrl, aabb_pcf_dp.
module aabb_pair_collision_finder_unit #(
  parameter int unsigned MAX_ENTITIES = 64,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  aabb_pcf_in_if.sink    req_i,
  aabb_pcf_res_if.source res_o
);

  aabb_pcf_pkg::cmd_t      cmd;
  aabb_pcf_pkg::sts_t      sts;
  aabb_pcf_pkg::req_kind_t kind;
  logic                    ready;

  assign kind.mode      = req_i.mode;
  assign kind.active    = req_i.active;
  assign kind.is_static = req_i.is_static;
  assign kind.is_box    = req_i.is_box;
  assign req_i.ready    = ready;

  aabb_pcf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (ready),
    .kind_i  (kind),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  aabb_pcf_dp #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .res_o  (res_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
